// ===== rtl/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared constants, types and helpers for the sentence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

  localparam int unsigned MAX_LINE = 256;
  localparam int unsigned CNT_W    = $clog2(MAX_LINE);
  localparam int unsigned LEN_W    = 9;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef enum logic [2:0] {
    ST_GOOD      = 3'd0,
    ST_BAD_START = 3'd1,
    ST_NO_STAR   = 3'd2,
    ST_BAD_FIELD = 3'd3,
    ST_MISMATCH  = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]       line_status;
    logic             forward_line;
    logic [7:0]       computed_sum;
    logic [7:0]       received_sum;
    logic [LEN_W-1:0] line_length;
    logic [7:0]       bad_start_run;
  } res_t;

  // bit 4 flags a valid digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nsc_if.sv =====
// ----------------------------------------------------------------------------
// nsc_if
// Valid/ready channel interfaces: byte input, line verdict, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface nsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] line_status;
  logic       forward_line;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;
  logic [8:0] line_length;
  logic [7:0] bad_start_run;

  modport source (output valid, output line_status, output forward_line,
                  output computed_sum, output received_sum, output line_length,
                  output bad_start_run, input ready);
  modport sink   (input valid, input line_status, input forward_line,
                  input computed_sum, input received_sum, input line_length,
                  input bad_start_run, output ready);
endinterface

interface nsc_cfg_if;
  logic valid;
  logic ready;
  logic forward_enable;

  modport source (output valid, output forward_enable, input ready);
  modport sink   (input valid, input forward_enable, output ready);
endinterface

`default_nettype wire

// ===== rtl/nmea_sentence_checker.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Frames a received byte stream into lines and checks each sentence's
// start character and hex checksum field, one verdict per non-empty line.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_i     in   data_byte
//  res_o    out  line_status, forward_line, computed_sum, received_sum,
//                line_length, bad_start_run
//  cfg_i    in   forward_enable
//
// One byte per cycle unless stalled: input register, then the line accumulators
// update and a verdict lands in the output register.
// Reset clears all line state, the run counter, and sets forward_enable.
// A stalled verdict holds the input register; in_i.ready drops only while
// the output register is full and not being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nsc_in_if.sink    in_i,
  nsc_out_if.source res_o,
  nsc_cfg_if.sink   cfg_i
);
  import nsc_pkg::*;

  logic       s1_vld_q, s1_vld_d;
  logic [7:0] s1_byte_q;
  logic       out_vld_q, out_vld_d;
  res_t       out_q;
  logic       fwd_en_q;
  logic       s1_go, acc_vld;
  res_t       acc_res;

  assign s1_go      = s1_vld_q && (!out_vld_q || res_o.ready);
  assign in_i.ready = !s1_vld_q || s1_go;
  assign cfg_i.ready = 1'b1;

  assign s1_vld_d  = (in_i.valid && in_i.ready) || (s1_vld_q && !s1_go);
  assign out_vld_d = acc_vld || (out_vld_q && !res_o.ready);

  nsc_line_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (s1_go),
    .byte_i     (s1_byte_q),
    .fwd_en_i   (fwd_en_q),
    .res_vld_o  (acc_vld),
    .res_o      (acc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_en_q  <= 1'b1;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        fwd_en_q <= cfg_i.forward_enable;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
    end
    if (acc_vld) begin
      out_q <= acc_res;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.line_status   = out_q.line_status;
  assign res_o.forward_line  = out_q.forward_line;
  assign res_o.computed_sum  = out_q.computed_sum;
  assign res_o.received_sum  = out_q.received_sum;
  assign res_o.line_length   = out_q.line_length;
  assign res_o.bad_start_run = out_q.bad_start_run;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |-> !acc_vld)
    else $error("pending verdict overwritten");

  a_stall_holds_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_go) |=> (s1_vld_q && $stable(s1_byte_q)))
    else $error("staged byte lost during stall");

  a_fwd_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.forward_line) |->
      (out_q.line_status == ST_GOOD))
    else $error("forward flag on a failed line");

endmodule

`default_nettype wire

// ===== rtl/nsc_line_acc.sv =====
// ----------------------------------------------------------------------------
// nsc_line_acc
// Per-line accumulators: start check, XOR sum, checksum field capture,
// length count and bad start run; emits one verdict per finished line.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_line_acc (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          byte_vld_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          fwd_en_i,
  output logic               res_vld_o,
  output nsc_pkg::res_t      res_o
);
  import nsc_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             start_q, start_d;
  logic [7:0]       xor_q, xor_d;
  logic             star_q, star_d;
  logic [1:0]       dig_q, dig_d;
  logic [7:0]       hex_q, hex_d;
  logic             inv_q, inv_d;
  logic [7:0]       run_q, run_d;

  logic             a_start, a_star, a_inv;
  logic [7:0]       a_xor, a_hex;
  logic [1:0]       a_dig;
  logic [4:0]       hv;
  logic             is_nl, first, overflow;
  logic [CNT_W:0]   cnt_inc;
  status_e          status;

  assign is_nl    = (byte_i == CH_NL);
  assign first    = (cnt_q == '0);
  assign cnt_inc  = {1'b0, cnt_q} + 1'b1;
  assign overflow = (cnt_inc >= (CNT_W+1)'(MAX_LINE));
  assign hv       = hex_digit(byte_i);

  // take the current byte into the line accumulators
  always_comb begin
    a_start = first ? (byte_i == CH_DOLLAR || byte_i == CH_BANG) : start_q;
    a_xor   = xor_q;
    if (!first && !star_q && byte_i != CH_STAR && byte_i != CH_DOLLAR &&
        byte_i != CH_BANG) begin
      a_xor = xor_q ^ byte_i;
    end
    a_star = star_q;
    a_dig  = dig_q;
    a_hex  = hex_q;
    a_inv  = inv_q;
    if (byte_i == CH_STAR) begin
      a_star = 1'b1;
      a_dig  = 2'd0;
      a_hex  = 8'd0;
      a_inv  = 1'b0;
    end else if (star_q && dig_q < 2'd2) begin
      a_inv = inv_q | ~hv[4];
      a_hex = {hex_q[3:0], hv[4] ? hv[3:0] : 4'd0};
      a_dig = dig_q + 2'd1;
    end
  end

  always_comb begin
    status = ST_GOOD;
    res_o  = '0;
    run_d  = run_q;
    if (!a_start) begin
      status = ST_BAD_START;
      if (run_q != 8'hFF) begin
        run_d = run_q + 8'd1;
      end
    end else begin
      run_d              = 8'd0;
      res_o.computed_sum = a_xor;
      if (!a_star) begin
        status = ST_NO_STAR;
      end else if (a_dig < 2'd2 || a_inv) begin
        status = ST_BAD_FIELD;
      end else begin
        res_o.received_sum = a_hex;
        status = (a_hex == a_xor) ? ST_GOOD : ST_MISMATCH;
      end
    end
    res_o.line_status   = status;
    res_o.forward_line  = (status == ST_GOOD) && fwd_en_i;
    res_o.line_length   = LEN_W'(cnt_inc);
    res_o.bad_start_run = run_d;
  end

  assign res_vld_o = byte_vld_i && is_nl && !first;

  always_comb begin
    cnt_d   = cnt_q;
    start_d = start_q;
    xor_d   = xor_q;
    star_d  = star_q;
    dig_d   = dig_q;
    hex_d   = hex_q;
    inv_d   = inv_q;
    if (byte_vld_i && (overflow && !is_nl || res_vld_o)) begin
      cnt_d   = '0;
      start_d = 1'b0;
      xor_d   = 8'd0;
      star_d  = 1'b0;
      dig_d   = 2'd0;
      hex_d   = 8'd0;
      inv_d   = 1'b0;
    end else if (byte_vld_i && !is_nl) begin
      cnt_d   = cnt_inc[CNT_W-1:0];
      start_d = a_start;
      xor_d   = a_xor;
      star_d  = a_star;
      dig_d   = a_dig;
      hex_d   = a_hex;
      inv_d   = a_inv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      start_q <= 1'b0;
      xor_q   <= 8'd0;
      star_q  <= 1'b0;
      dig_q   <= 2'd0;
      hex_q   <= 8'd0;
      inv_q   <= 1'b0;
      run_q   <= 8'd0;
    end else begin
      cnt_q   <= cnt_d;
      start_q <= start_d;
      xor_q   <= xor_d;
      star_q  <= star_d;
      dig_q   <= dig_d;
      hex_q   <= hex_d;
      inv_q   <= inv_d;
      if (res_vld_o) begin
        run_q <= run_d;
      end
    end
  end

  a_clear_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |=> (cnt_q == '0 && !star_q && xor_q == 8'd0))
    else $error("line state not cleared after verdict");

  a_bad_start_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.line_status == ST_BAD_START) |->
      (res_o.computed_sum == 8'd0 && res_o.received_sum == 8'd0))
    else $error("bad start line carries sums");

  a_good_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.line_status != ST_BAD_START) |=> (run_q == 8'd0))
    else $error("run counter not cleared on good start");

  a_run_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.line_status == ST_BAD_START && run_q != 8'hFF) |=>
      (run_q == $past(run_q) + 8'd1))
    else $error("run counter did not advance");

endmodule

`default_nettype wire

// ===== tb/nmea_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// nmea_verdict_checker
// Watches the byte, verdict and config channels of the sentence checker,
// predicts one verdict per finished non-empty line and compares every
// accepted verdict field by field against the oldest one due.
// ----------------------------------------------------------------------------
module nmea_verdict_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  nsc_in_if           in_m,
  nsc_out_if          res_m,
  nsc_cfg_if          cfg_m,
  output int unsigned errors_o,
  output int unsigned due_o,
  output int unsigned bytes_o,
  output int unsigned verdicts_o,
  output logic [4:0]  status_seen_o,
  output logic [7:0]  peak_run_o
);
  import nsc_pkg::*;

  res_t        verdicts_due[$];
  logic [8:0]  line_chars;
  logic        lead_ok;
  logic        star_seen;
  logic        field_bad;
  logic        fwd_en;
  logic [7:0]  sum_acc;
  logic [7:0]  field_val;
  logic [7:0]  bad_run;
  int unsigned field_digits;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic void clear_line();
    line_chars   = '0;
    lead_ok      = 1'b0;
    star_seen    = 1'b0;
    field_bad    = 1'b0;
    sum_acc      = '0;
    field_val    = '0;
    field_digits = 0;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    int nib;
    if (line_chars == 0) begin
      lead_ok = (c == CH_DOLLAR || c == CH_BANG);
    end else if (!star_seen && c != CH_STAR && c != CH_DOLLAR && c != CH_BANG) begin
      sum_acc = sum_acc ^ c;
    end
    if (c == CH_STAR) begin
      star_seen    = 1'b1;
      field_digits = 0;
      field_val    = '0;
      field_bad    = 1'b0;
    end else if (star_seen && field_digits < 2) begin
      nib = hex_nibble(c);
      if (nib < 0) begin
        field_bad = 1'b1;
        nib       = 0;
      end
      field_val = {field_val[3:0], nib[3:0]};
      field_digits++;
    end
  endfunction

  // returns 1 when the byte closes a non-empty line
  function automatic bit predict_verdict(input logic [7:0] c, output res_t v);
    v = '0;
    if (c != CH_NL) begin
      if (line_chars + 1 >= MAX_LINE) begin
        clear_line();
      end else begin
        take_char(c);
        line_chars++;
      end
      return 1'b0;
    end
    if (line_chars == 0) return 1'b0;
    take_char(c);
    v.line_length = line_chars + 9'd1;
    if (!lead_ok) begin
      v.line_status = ST_BAD_START;
      if (bad_run != 8'hFF) bad_run++;
    end else begin
      bad_run        = '0;
      v.computed_sum = sum_acc;
      if (!star_seen) begin
        v.line_status = ST_NO_STAR;
      end else if (field_digits < 2 || field_bad) begin
        v.line_status = ST_BAD_FIELD;
      end else begin
        v.received_sum = field_val;
        v.line_status  = (field_val == sum_acc) ? ST_GOOD : ST_MISMATCH;
      end
    end
    v.forward_line  = (v.line_status == ST_GOOD) && fwd_en;
    v.bad_start_run = bad_run;
    clear_line();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      clear_line();
      bad_run = '0;
      fwd_en  = 1'b1;
      verdicts_due.delete();
      errors_o      = 0;
      due_o         = 0;
      bytes_o       = 0;
      verdicts_o    = 0;
      status_seen_o = '0;
      peak_run_o    = '0;
    end else begin
      if (res_m.valid && res_m.ready) begin
        verdicts_o++;
        if (res_m.line_status <= 3'd4) status_seen_o[res_m.line_status] = 1'b1;
        if (verdicts_due.size() == 0) begin
          $error("verdict item with none due: line_status %0d, line_length %0d",
                 res_m.line_status, res_m.line_length);
          errors_o++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("line_status", want.line_status, res_m.line_status);
          check_field("forward_line", want.forward_line, res_m.forward_line);
          check_field("computed_sum", want.computed_sum, res_m.computed_sum);
          check_field("received_sum", want.received_sum, res_m.received_sum);
          check_field("line_length", want.line_length, res_m.line_length);
          check_field("bad_start_run", want.bad_start_run, res_m.bad_start_run);
        end
      end
      if (cfg_m.valid && cfg_m.ready) fwd_en = cfg_m.forward_enable;
      if (in_m.valid && in_m.ready) begin
        bytes_o++;
        if (predict_verdict(in_m.data_byte, want)) verdicts_due.push_back(want);
      end
      if (bad_run > peak_run_o) peak_run_o = bad_run;
      due_o = verdicts_due.size();
    end
  end

endmodule

// ===== tb/tb_nmea_sentence_checker.sv =====
// ----------------------------------------------------------------------------
// tb_nmea_sentence_checker
// Drives byte streams of well-formed, broken and noisy sentences into the
// checker under random gaps, output stalls and one long output hold-off,
// toggles forward enable between phases, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker;
  import nsc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic        clk_i;
  logic        rst_ni;
  int unsigned errors;
  int unsigned due;
  int unsigned bytes_seen;
  int unsigned verdicts;
  logic [4:0]  status_seen;
  logic [7:0]  peak_run;
  bit          gaps_on;
  bit          stalls_on;
  bit          hold_go;
  int unsigned burst_left;
  logic [7:0]  line_q[$];

  nsc_in_if  in_ch();
  nsc_out_if res_ch();
  nsc_cfg_if cfg_ch();

  nmea_sentence_checker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  nmea_verdict_checker u_verdicts (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_m          (in_ch),
    .res_m         (res_ch),
    .cfg_m         (cfg_ch),
    .errors_o      (errors),
    .due_o         (due),
    .bytes_o       (bytes_seen),
    .verdicts_o    (verdicts),
    .status_seen_o (status_seen),
    .peak_run_o    (peak_run)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : receiver
    int unsigned hold_left;
    int unsigned slot;
    logic [31:0] pat;
    bit          held;
    res_ch.ready = 1'b0;
    hold_left    = 0;
    slot         = 0;
    held         = 1'b0;
    pat          = '1;
    forever begin
      @(negedge clk_i);
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (slot == 0) begin
        case ($urandom_range(0, 3))
          0:       pat = '1;
          1:       pat = $urandom | $urandom;
          2:       pat = $urandom;
          default: pat = $urandom & $urandom;
        endcase
        if (!stalls_on) pat = '1;
      end
      res_ch.ready = (hold_left == 0) && pat[slot];
      if (hold_left != 0) hold_left--;
      slot = (slot + 1) % 32;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no item accepted for %0d cycles", QUIET_LIMIT);
    $display("nmea_sentence_checker test failed");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic put_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_q[i]) put_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_forward(input logic v);
    wait_idle();
    cfg_ch.forward_enable = v;
    cfg_ch.valid          = 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] base;
    if (n < 10) return "0" + {4'd0, n};
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + {4'd0, n} - 8'd10;
  endfunction

  // characters just outside the hex digit ranges, plus the byte extremes
  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 7))
      0:       return 8'h2F;
      1:       return 8'h3A;
      2:       return 8'h40;
      3:       return 8'h47;
      4:       return 8'h60;
      5:       return 8'h67;
      6:       return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = 8'($urandom_range(0, 255));
      1:       c = $urandom_range(0, 1) ? CH_DOLLAR : CH_BANG;
      default: c = 8'($urandom_range(8'h20, 8'h7E));
    endcase
    if (c == CH_NL || c == CH_STAR) c = "#";
    return c;
  endfunction

  function automatic logic [7:0] bad_lead();
    logic [7:0] c;
    c = body_char();
    if (c == CH_DOLLAR || c == CH_BANG) c = "x";
    return c;
  endfunction

  task automatic add_body(input int unsigned n, inout logic [7:0] sum);
    logic [7:0] c;
    repeat (n) begin
      c = body_char();
      line_q.push_back(c);
      if (c != CH_DOLLAR && c != CH_BANG) sum = sum ^ c;
    end
  endtask

  // 0-44 good, 45-54 mismatch, 55-62 bad hex, 63-69 short field,
  // 70-76 no star, 77-83 bad start, 84-89 two stars, 90-95 noise, else empty
  task automatic random_line();
    int unsigned kind;
    logic [7:0]  sum;
    logic [7:0]  field;
    logic [7:0]  d0;
    logic [7:0]  d1;
    kind = $urandom_range(0, 99);
    sum  = '0;
    if (kind >= 96) begin
      line_q.push_back(CH_NL);
    end else if (kind >= 90) begin
      repeat ($urandom_range(1, 16)) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(CH_NL);
    end else begin
      if (kind >= 77 && kind <= 83) line_q.push_back(bad_lead());
      else line_q.push_back($urandom_range(0, 1) ? CH_DOLLAR : CH_BANG);
      add_body($urandom_range(0, 8), sum);
      if (kind < 70 || kind >= 77) begin
        line_q.push_back(CH_STAR);
        if (kind >= 84) begin
          repeat ($urandom_range(0, 3)) line_q.push_back(body_char());
          line_q.push_back(CH_STAR);
        end
        field = sum;
        if (kind >= 45 && kind <= 54) field = sum ^ 8'($urandom_range(1, 255));
        if (kind >= 63 && kind <= 69) begin
          if ($urandom_range(0, 1)) line_q.push_back(hex_char(field[7:4]));
        end else begin
          d0 = hex_char(field[7:4]);
          d1 = hex_char(field[3:0]);
          if (kind >= 55 && kind <= 62) begin
            if ($urandom_range(0, 1)) d0 = non_hex_char();
            else d1 = non_hex_char();
          end
          line_q.push_back(d0);
          line_q.push_back(d1);
          repeat ($urandom_range(0, 2)) line_q.push_back(body_char());
        end
      end
      line_q.push_back(CH_NL);
    end
    send_line();
  endtask

  initial begin : stimulus
    logic [7:0] sum;
    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.data_byte       = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.forward_enable = 1'b0;
    burst_left            = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed lines, forwarding at its reset value
    stalls_on = 1'b1;
    gaps_on   = 1'b1;
    send_text("\n");
    send_text("$*00\n");
    send_text("!A*41\n");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_NL);
    put_byte(CH_DOLLAR);
    put_byte(8'hFF);
    put_byte(CH_NL);
    send_text("$*5\n");
    send_text("$A*00\n");

    write_forward(1'b0);
    repeat (4) random_line();

    // long output hold-off while bytes keep coming
    write_forward(1'b1);
    stalls_on = 1'b0;
    gaps_on   = 1'b0;
    hold_go   = 1'b1;
    repeat (5) random_line();
    stalls_on = 1'b1;
    gaps_on   = 1'b1;
    repeat (2) random_line();

    // bad start run up to saturation, then cleared by a good line
    write_forward(1'b0);
    gaps_on = 1'b0;
    repeat (258) begin
      line_q.push_back(bad_lead());
      line_q.push_back(CH_NL);
      send_line();
    end
    send_text("$*00\n");

    // longest accepted line, then one dropped for length
    write_forward(1'b1);
    gaps_on = 1'b1;
    sum     = '0;
    line_q.push_back(CH_DOLLAR);
    add_body(MAX_LINE - 5, sum);
    line_q.push_back(CH_STAR);
    line_q.push_back(hex_char(sum[7:4]));
    line_q.push_back(hex_char(sum[3:0]));
    line_q.push_back(CH_NL);
    send_line();
    line_q.push_back(CH_DOLLAR);
    add_body(MAX_LINE - 1, sum);
    send_line();
    send_text("!*00\n");
    repeat (2) random_line();

    wait_idle();
    $display("%0d bytes sent, %0d line verdicts checked, status codes seen %b",
             bytes_seen, verdicts, status_seen);
    $display("forwarding on and off, peak bad-start run %0d, max-length and dropped lines",
             peak_run);
    if (errors == 0) begin
      $display("nmea_sentence_checker test passed");
    end else begin
      $display("nmea_sentence_checker test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nsc_pkg.sv
rtl/nsc_if.sv
rtl/nsc_line_acc.sv
rtl/nmea_sentence_checker.sv
tb/nmea_verdict_checker.sv
tb/tb_nmea_sentence_checker.sv
